@@ rtl/abr_pkg.sv @@
package abr_pkg;

   localparam int COEF_BITS         = 5;
   localparam int FRAC_BITS         = 8;
   localparam int ACC_BITS          = 16;
   localparam int STEP_IN_BITS      = 8;
   localparam int STEP_BITS_DEFAULT = 8;

   // |end - start| << 8 needs 13 bits
   localparam int DIV_BITS = COEF_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(DIV_BITS);

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 24;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef struct packed {
      logic                start;
      logic                neg;
      logic [DIV_BITS-1:0] mag;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [ACC_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/abr_div.sv @@
module abr_div
   import abr_pkg::*;
#(
   parameter int STEP_BITS = STEP_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  div_req_type          div_req,
   input  logic [STEP_BITS-1:0] divisor,
   output div_rsp_type          div_rsp
);

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [STEP_BITS-1:0] rem_ff;
   logic [DIV_BITS-1:0]  quo_ff;

   logic [STEP_BITS:0]   shifted;
   logic [STEP_BITS:0]   trial;
   logic                 fits;
   logic [STEP_BITS-1:0] rem_in;
   logic [DIV_BITS-1:0]  quo_in;
   logic [ACC_BITS-1:0]  quo_wide;

   // one restoring quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_BITS-1]};
      trial   = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
      rem_in  = fits ? trial[STEP_BITS-1:0] : shifted[STEP_BITS-1:0];
      quo_in  = {quo_ff[DIV_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.mag;
         neg_ff <= div_req.neg;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // truncation toward zero: divide magnitudes, then restore the sign
   assign quo_wide         = {{(ACC_BITS-DIV_BITS){1'b0}}, quo_ff};
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_wide + 1'b1) : quo_wide;

   property p_no_start_while_busy;
      @(posedge clock) disable iff (reset) busy_ff |-> !div_req.start;
   endproperty
   a_no_start_while_busy: assert property (p_no_start_while_busy)
      else $error("divider restarted mid-pass");

   property p_done_after_last;
      @(posedge clock) disable iff (reset)
         (busy_ff && !div_req.start && cnt_ff == CNT_LAST) |=> (done_ff && !busy_ff);
   endproperty
   a_done_after_last: assert property (p_done_after_last)
      else $error("divider missed its done pulse");

   property p_rem_below_divisor;
      @(posedge clock) disable iff (reset) busy_ff |-> (rem_ff < divisor);
   endproperty
   a_rem_below_divisor: assert property (p_rem_below_divisor)
      else $error("partial remainder out of range");

endmodule

@@ rtl/alpha_blend_ramp_top.sv @@
// tick or zero-step start request: result registered on accept, valid in the cycle after accept
// start with nonzero steps: result after two passes of the divider (S_LAUNCH_A, S_WAIT_A, S_LAUNCH_B, S_WAIT_B)
// throughput: one request per result; no new request while a division runs
// the single shared divider sets the start latency, one quotient bit per cycle
// reset: synchronous active-high, clears accumulators, deltas, targets, steps, phase
module alpha_blend_ramp_top
   import abr_pkg::*;
#(
   parameter int STEP_BITS = STEP_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // a_start[4:0], b_start[9:5], a_end[14:10], b_end[19:15], step_total[27:20], zero pad
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // func[0]
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // blend_word[15:0], busy_res[16], zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int STW = STEP_BITS + STEP_IN_BITS;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_LAUNCH_A = 3'd1;
   localparam logic [2:0] S_WAIT_A   = 3'd2;
   localparam logic [2:0] S_LAUNCH_B = 3'd3;
   localparam logic [2:0] S_WAIT_B   = 3'd4;

   logic [2:0]           state_ff;
   logic [ACC_BITS-1:0]  acc_a_ff, acc_b_ff, delta_a_ff, delta_b_ff;
   logic [COEF_BITS-1:0] target_a_ff, target_b_ff;
   logic [STEP_BITS-1:0] steps_left_ff;
   logic                 phase_ff;
   logic                 rsp_valid_ff;
   logic [ACC_BITS-1:0]  rsp_word_ff;
   logic                 rsp_busy_ff;

   logic [ACC_BITS-1:0]  acc_a_in, acc_b_in;
   logic [STEP_BITS-1:0] steps_left_in;
   logic                 phase_in;

   logic                 req_func;
   logic [COEF_BITS-1:0] a_start, b_start, a_end, b_end;
   logic [STW-1:0]       step_wide;
   logic [STEP_BITS-1:0] step_req;
   logic                 req_fire;
   logic                 rsp_free;

   logic [COEF_BITS-1:0] div_from, div_to;
   logic [COEF_BITS:0]   diff;
   logic [COEF_BITS-1:0] diff_mag;
   logic [STEP_BITS-1:0] steps_dec;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign req_func  = req_tuser;
   assign a_start   = req_tdata[4:0];
   assign b_start   = req_tdata[9:5];
   assign a_end     = req_tdata[14:10];
   assign b_end     = req_tdata[19:15];
   assign step_wide = {{STEP_BITS{1'b0}}, req_tdata[27:20]};
   assign step_req  = step_wide[STEP_BITS-1:0];

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-ACC_BITS-1){1'b0}}, rsp_busy_ff, rsp_word_ff};

   // tick update of the ramp
   always_comb begin
      acc_a_in      = acc_a_ff;
      acc_b_in      = acc_b_ff;
      steps_left_in = steps_left_ff;
      phase_in      = phase_ff;
      steps_dec     = steps_left_ff - 1'b1;
      if (steps_left_ff != '0) begin
         if (!phase_ff) begin
            acc_a_in = acc_a_ff + delta_a_ff;
            phase_in = 1'b1;
         end else begin
            steps_left_in = steps_dec;
            phase_in      = 1'b0;
            if (steps_dec != '0) begin
               acc_b_in = acc_b_ff + delta_b_ff;
            end else begin
               acc_a_in = {3'b000, target_a_ff, {FRAC_BITS{1'b0}}};
               acc_b_in = {3'b000, target_b_ff, {FRAC_BITS{1'b0}}};
            end
         end
      end
   end

   // signed span feeding the shared divider
   always_comb begin
      div_from = (state_ff == S_LAUNCH_B) ? acc_b_ff[ACC_BITS-4:FRAC_BITS] :
                                            acc_a_ff[ACC_BITS-4:FRAC_BITS];
      div_to   = (state_ff == S_LAUNCH_B) ? target_b_ff : target_a_ff;
      diff     = {1'b0, div_to} - {1'b0, div_from};
      diff_mag = diff[COEF_BITS] ? COEF_BITS'(~diff + 1'b1) : diff[COEF_BITS-1:0];
      div_req.start = (state_ff == S_LAUNCH_A) || (state_ff == S_LAUNCH_B);
      div_req.neg   = diff[COEF_BITS];
      div_req.mag   = {diff_mag, {FRAC_BITS{1'b0}}};
   end

   abr_div #(
      .STEP_BITS(STEP_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .divisor(steps_left_ff),
      .div_rsp(div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         acc_a_ff      <= '0;
         acc_b_ff      <= '0;
         delta_a_ff    <= '0;
         delta_b_ff    <= '0;
         target_a_ff   <= '0;
         target_b_ff   <= '0;
         steps_left_ff <= '0;
         phase_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_func == FUNC_START) begin
                     acc_a_ff      <= {3'b000, a_start, {FRAC_BITS{1'b0}}};
                     acc_b_ff      <= {3'b000, b_start, {FRAC_BITS{1'b0}}};
                     target_a_ff   <= a_end;
                     target_b_ff   <= b_end;
                     phase_ff      <= 1'b0;
                     steps_left_ff <= step_req;
                     delta_a_ff    <= '0;
                     delta_b_ff    <= '0;
                     if (step_req != '0) begin
                        state_ff <= S_LAUNCH_A;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        rsp_word_ff  <= {3'b000, b_start, 3'b000, a_start};
                        rsp_busy_ff  <= 1'b0;
                     end
                  end else begin
                     acc_a_ff      <= acc_a_in;
                     acc_b_ff      <= acc_b_in;
                     steps_left_ff <= steps_left_in;
                     phase_ff      <= phase_in;
                     rsp_valid_ff  <= 1'b1;
                     rsp_word_ff   <= {acc_b_in[ACC_BITS-1:FRAC_BITS],
                                       acc_a_in[ACC_BITS-1:FRAC_BITS]};
                     rsp_busy_ff   <= (steps_left_in != '0);
                  end
               end
            end
            S_LAUNCH_A: begin
               state_ff <= S_WAIT_A;
            end
            S_WAIT_A: begin
               if (div_rsp.done) begin
                  delta_a_ff <= div_rsp.quotient;
                  state_ff   <= S_LAUNCH_B;
               end
            end
            S_LAUNCH_B: begin
               state_ff <= S_WAIT_B;
            end
            S_WAIT_B: begin
               if (div_rsp.done) begin
                  delta_b_ff   <= div_rsp.quotient;
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= {acc_b_ff[ACC_BITS-1:FRAC_BITS],
                                   acc_a_ff[ACC_BITS-1:FRAC_BITS]};
                  rsp_busy_ff  <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   property p_done_in_wait;
      @(posedge clock) disable iff (reset)
         div_rsp.done |-> (state_ff == S_WAIT_A || state_ff == S_WAIT_B);
   endproperty
   a_done_in_wait: assert property (p_done_in_wait)
      else $error("divider result arrived outside a wait state");

   property p_start_holds_rsp;
      @(posedge clock) disable iff (reset)
         (req_fire && req_func == FUNC_START && step_req != '0) |=> !rsp_valid_ff;
   endproperty
   a_start_holds_rsp: assert property (p_start_holds_rsp)
      else $error("result raised before deltas were ready");

   property p_busy_matches_steps;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> (rsp_busy_ff == (steps_left_ff != '0));
   endproperty
   a_busy_matches_steps: assert property (p_busy_matches_steps)
      else $error("busy flag disagrees with remaining steps");

   property p_phase_needs_steps;
      @(posedge clock) disable iff (reset) phase_ff |-> (steps_left_ff != '0);
   endproperty
   a_phase_needs_steps: assert property (p_phase_needs_steps)
      else $error("second phase pending with no steps left");

endmodule

@@ tb/sv/alpha_blend_ramp_top_tb.sv @@
`timescale 1ns / 100ps

module alpha_blend_ramp_top_tb;
   import abr_pkg::*;

   localparam int RAMP_STEP_BITS = STEP_BITS_DEFAULT;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 80;

   typedef struct {
      logic       func;
      logic [4:0] a_start;
      logic [4:0] b_start;
      logic [4:0] a_end;
      logic [4:0] b_end;
      logic [7:0] step_total;
   } fade_req_type;

   typedef struct {
      logic [15:0] blend_word;
      logic        busy_res;
   } blend_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tuser = FUNC_TICK;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   fade_req_type  pending_reqs[$];
   blend_rsp_type blend_expect[$];
   fade_req_type  in_flight;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_go = 1'b0;
   logic hold_taken = 1'b0;
   int hold_left = 0;
   int idle_cycles = 0;

   int errors = 0;
   int n_starts = 0;
   int n_ticks = 0;
   int n_checked = 0;
   int n_busy = 0;

   // predictor state
   logic [15:0]               ramp_a = '0;
   logic [15:0]               ramp_b = '0;
   logic [15:0]               step_a = '0;
   logic [15:0]               step_b = '0;
   logic [4:0]                goal_a = '0;
   logic [4:0]                goal_b = '0;
   logic [RAMP_STEP_BITS-1:0] steps_remaining = '0;
   logic                      tick_phase = 1'b0;

   alpha_blend_ramp_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // signed quotient, truncated toward zero, kept to 16 bits
   function automatic logic [15:0] fade_delta(int from, int to, int steps);
      int q;
      q = ((to - from) * 256) / steps;
      return q[15:0];
   endfunction

   function automatic blend_rsp_type predict_blend(fade_req_type r);
      blend_rsp_type res;
      logic [RAMP_STEP_BITS-1:0] st;
      st = r.step_total[RAMP_STEP_BITS-1:0];
      if (r.func == FUNC_START) begin
         ramp_a = {3'b000, r.a_start, 8'h00};
         ramp_b = {3'b000, r.b_start, 8'h00};
         goal_a = r.a_end;
         goal_b = r.b_end;
         tick_phase = 1'b0;
         steps_remaining = st;
         if (st != 0) begin
            step_a = fade_delta(r.a_start, r.a_end, st);
            step_b = fade_delta(r.b_start, r.b_end, st);
         end else begin
            step_a = '0;
            step_b = '0;
         end
      end else if (steps_remaining != 0) begin
         if (tick_phase == 1'b0) begin
            ramp_a = ramp_a + step_a;
            tick_phase = 1'b1;
         end else begin
            steps_remaining = steps_remaining - 1'b1;
            if (steps_remaining != 0) begin
               ramp_b = ramp_b + step_b;
            end else begin
               ramp_a = {3'b000, goal_a, 8'h00};
               ramp_b = {3'b000, goal_b, 8'h00};
            end
            tick_phase = 1'b0;
         end
      end
      res.blend_word = {ramp_b[15:8], ramp_a[15:8]};
      res.busy_res = (steps_remaining != 0);
      return res;
   endfunction

   always @(posedge clock) begin : drive
      fade_req_type nxt;
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= FUNC_TICK;
      end else begin
         if (req_tvalid && req_tready) begin
            blend_expect.push_back(predict_blend(in_flight));
            if (in_flight.func == FUNC_START) n_starts++;
            else n_ticks++;
         end
         if (!req_tvalid || req_tready) begin
            offer = (pending_reqs.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               nxt = pending_reqs.pop_front();
               in_flight <= nxt;
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0000, nxt.step_total, nxt.b_end, nxt.a_end,
                             nxt.b_start, nxt.a_start};
               req_tuser <= nxt.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : observe
      blend_rsp_type want;
      logic ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (blend_expect.size() == 0) begin
               $error("result with no request pending: data %h", rsp_tdata);
               errors++;
            end else begin
               want = blend_expect.pop_front();
               n_checked++;
               if (want.busy_res) n_busy++;
               if (rsp_tdata[15:0] !== want.blend_word) begin
                  $error("blend_word: expected %h, got %h", want.blend_word, rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[16] !== want.busy_res) begin
                  $error("busy_res: expected %b, got %b", want.busy_res, rsp_tdata[16]);
                  errors++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            ready_next = 1'b0;
         end else if (hold_go && !hold_taken) begin
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
            ready_next = 1'b0;
         end else begin
            ready_next = ($urandom_range(99) >= recv_stall_pct);
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic push_req(logic func, int as, int bs, int ae, int be, int st);
      fade_req_type r;
      r.func = func;
      r.a_start = as[4:0];
      r.b_start = bs[4:0];
      r.a_end = ae[4:0];
      r.b_end = be[4:0];
      r.step_total = st[7:0];
      pending_reqs.push_back(r);
   endtask

   task automatic push_ticks(int count);
      for (int i = 0; i < count; i++) begin
         push_req(FUNC_TICK, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                  $urandom_range(31), $urandom_range(255));
      end
   endtask

   // mostly complete fades, some cut short, some zero-step starts and stray ticks
   task automatic push_random(int count);
      int made;
      int pick;
      int st;
      int ticks;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            st = ($urandom_range(7) == 0) ? $urandom_range(13, 255) : $urandom_range(1, 12);
            if (st > 12) ticks = $urandom_range(0, 40);
            else if ($urandom_range(4) == 0) ticks = $urandom_range(0, 2 * st - 1);
            else ticks = 2 * st + $urandom_range(0, 2);
         end else if (pick < 88) begin
            st = 0;
            ticks = $urandom_range(0, 3);
         end else begin
            st = -1;
            ticks = $urandom_range(1, 4);
         end
         if (st >= 0) begin
            push_req(FUNC_START, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                     $urandom_range(31), st);
            made++;
         end
         push_ticks(ticks);
         made += ticks;
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || blend_expect.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tick while idle right after reset
      push_req(FUNC_TICK, 0, 0, 0, 0, 0);
      // zero step count, extremes of the coefficients
      push_req(FUNC_START, 31, 0, 0, 31, 0);
      push_req(FUNC_TICK, 0, 0, 0, 0, 0);
      // single step, rising
      push_req(FUNC_START, 0, 0, 31, 31, 1);
      push_ticks(3);
      // longest fade, falling, abandoned by a new start
      push_req(FUNC_START, 31, 31, 0, 0, 255);
      push_ticks(3);
      push_req(FUNC_START, 0, 31, 31, 0, 3);
      push_ticks(7);
      push_req(FUNC_START, 31, 31, 31, 31, 255);
      push_ticks(2);
      // uneven division
      push_req(FUNC_START, 7, 24, 19, 3, 5);
      push_ticks(2);
      wait_drained();

      set_idling(0, 0);
      push_random(275);
      wait_drained();
      set_idling(84, 0);
      push_random(275);
      wait_drained();
      set_idling(0, 84);
      push_random(275);
      wait_drained();
      set_idling(33, 33);
      push_random(275);
      wait_drained();

      // long receiver hold-off while requests keep coming
      set_idling(0, 0);
      hold_go <= 1'b1;
      push_random(150);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (blend_expect.size() != 0) begin
         $error("%0d results never arrived", blend_expect.size());
         errors++;
      end
      $display("covered %0d fade starts and %0d ticks under four idling mixes and a long stall",
               n_starts, n_ticks);
      $display("%0d results checked, %0d while a fade was running, %0d errors",
               n_checked, n_busy, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
